FILE: hdl/psa_pkg.sv
// ----------------------------------------------------------------------------
// psa_pkg
// Types and constants shared by the partitioned slab allocator modules.
// ----------------------------------------------------------------------------
package psa_pkg;

    localparam int KEY_W      = 12;
    localparam int SLAB_OUT_W = 10;
    localparam int KPP_W      = 13;
    localparam int THR_W      = 8;
    localparam int RCNT_W     = 13;

    localparam logic [KPP_W-1:0] KPP_RESET = 13'd256;
    localparam logic [THR_W-1:0] THR_RESET = 8'd4;

    // register index, taken from paddr[2]
    localparam logic REG_KPP = 1'b0;
    localparam logic REG_THR = 1'b1;

    typedef enum logic [1:0] {
        REQ_INSERT    = 2'd0,
        REQ_GET       = 2'd1,
        REQ_FREE_PART = 2'd2,
        REQ_FREE_SLAB = 2'd3
    } t_req_type;

    typedef enum logic [1:0] {
        STS_OK           = 2'd0,
        STS_NOT_MAPPED   = 2'd1,
        STS_NO_SLAB      = 2'd2,
        STS_OUT_OF_RANGE = 2'd3
    } t_status;

    typedef struct packed {
        t_req_type          req_type;
        logic [KEY_W-1:0]   key;
    } t_req;

    typedef struct packed {
        t_status                 status;
        logic [SLAB_OUT_W-1:0]   slab_index;
        logic                    released;
        logic [RCNT_W-1:0]       released_count;
    } t_result;

    typedef struct packed {
        logic               done;
        logic [KEY_W-1:0]   quotient;
        logic [KEY_W-1:0]   remainder;
    } t_div_res;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_DIV,
        ST_FIFO_USE,
        ST_KV_USE,
        ST_DREF_USE,
        ST_WALK_RD,
        ST_WALK_USE,
        ST_DONE
    } t_state;

endpackage

FILE: hdl/partitioned_slab_allocator_core.sv
// ----------------------------------------------------------------------------
// partitioned_slab_allocator_core
// Maps keys to slabs drawn from a FIFO free list, with partition frees.
// ----------------------------------------------------------------------------
// After reset the block runs a clearing pass over max(NUM_KEYS, NUM_SLABS)
// entries with busy high (configuration writes are taken meanwhile). Each
// request then finds its partition on a shared bit-serial divider; out of
// range then ends, get reads the key map, insert the free list head, free
// slab the key map then the dereference count, and free partition reads the
// key map key by key in ST_WALK_RD, clearing mapped keys in ST_WALK_USE. Busy
// stays high until the result cycle ends. Each result is shown on o_result
// for one cycle with o_done high; it cannot be stalled.
module partitioned_slab_allocator_core #(
    parameter int NUM_SLABS      = 1024,
    parameter int NUM_KEYS       = 4096,
    parameter int NUM_PARTITIONS = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 start,
    output logic                 busy,
    input  psa_pkg::t_req        i_req,
    output logic                 o_done,
    output psa_pkg::t_result     o_result,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [2:0]           paddr,
    input  logic [31:0]          pwdata,
    output logic [31:0]          prdata,
    output logic                 pready
);

    localparam int SW    = (NUM_SLABS > 1) ? $clog2(NUM_SLABS) : 1;
    localparam int KW    = (NUM_KEYS > 1) ? $clog2(NUM_KEYS) : 1;
    localparam int CNTW  = $clog2(NUM_SLABS + 1);
    localparam int MAXN  = (NUM_KEYS > NUM_SLABS) ? NUM_KEYS : NUM_SLABS;
    localparam int CLW   = $clog2(MAXN);
    localparam int WW    = psa_pkg::KEY_W + 2;

    // configuration
    logic [psa_pkg::KPP_W-1:0] r_kpp;
    logic [psa_pkg::THR_W-1:0] r_thr;
    logic [psa_pkg::KPP_W-1:0] kpp_eff;

    assign pready  = 1'b1;
    assign kpp_eff = (r_kpp == '0) ? psa_pkg::KPP_W'(1) : r_kpp;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kpp <= psa_pkg::KPP_RESET;
            r_thr <= psa_pkg::THR_RESET;
        end else if (psel && penable && pwrite) begin
            if (paddr[2] == psa_pkg::REG_KPP) begin
                r_kpp <= pwdata[psa_pkg::KPP_W-1:0];
            end else begin
                r_thr <= pwdata[psa_pkg::THR_W-1:0];
            end
        end
    end

    always_comb begin
        if (paddr[2] == psa_pkg::REG_KPP) begin
            prdata = 32'(r_kpp);
        end else begin
            prdata = 32'(r_thr);
        end
    end

    // sequencer state
    psa_pkg::t_state            r_state, n_state;
    logic [CLW-1:0]             r_clr, n_clr;
    psa_pkg::t_req              r_req, n_req;
    logic [SW-1:0]              r_head, n_head;
    logic [SW-1:0]              r_tail, n_tail;
    logic [CNTW-1:0]            r_fifo_count, n_fifo_count;
    psa_pkg::t_status           r_status, n_status;
    logic [SW-1:0]              r_slab, n_slab;
    logic [psa_pkg::RCNT_W-1:0] r_rel_cnt, n_rel_cnt;
    logic [WW-1:0]              r_walk, n_walk;
    logic [WW-1:0]              r_end, n_end;

    // memories
    logic [SW:0]               kv_mem   [NUM_KEYS];
    logic [SW-1:0]             fifo_mem [NUM_SLABS];
    logic [psa_pkg::THR_W-1:0] dref_mem [NUM_SLABS];

    logic [SW:0]               r_kv_rd;
    logic [SW-1:0]             r_fifo_rd;
    logic [psa_pkg::THR_W-1:0] r_dref_rd;

    logic                      kv_we;
    logic [KW-1:0]             kv_waddr;
    logic [SW:0]               kv_wdata;
    logic [KW-1:0]             kv_raddr;
    logic                      fifo_we;
    logic [SW-1:0]             fifo_waddr;
    logic [SW-1:0]             fifo_wdata;
    logic                      dref_we;
    logic [SW-1:0]             dref_waddr;
    logic [psa_pkg::THR_W-1:0] dref_wdata;
    logic [SW-1:0]             dref_raddr;

    always_ff @(posedge i_clk) begin
        if (kv_we) begin
            kv_mem[kv_waddr] <= kv_wdata;
        end
        r_kv_rd <= kv_mem[kv_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (fifo_we) begin
            fifo_mem[fifo_waddr] <= fifo_wdata;
        end
        r_fifo_rd <= fifo_mem[r_head];
    end

    always_ff @(posedge i_clk) begin
        if (dref_we) begin
            dref_mem[dref_waddr] <= dref_wdata;
        end
        r_dref_rd <= dref_mem[dref_raddr];
    end

    psa_pkg::t_div_res          div_res;
    logic                       div_start;

    psa_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (i_req.key),
        .i_divisor  (kpp_eff),
        .o_res      (div_res)
    );

    logic                       push_en;
    logic [SW-1:0]              push_slab;
    logic                       oor;
    logic [psa_pkg::KEY_W-1:0]  part_base;
    logic [WW-1:0]              part_end;
    logic [psa_pkg::THR_W-1:0]  dref_inc;

    assign oor = ({5'b0, r_req.key} >= 17'(NUM_KEYS))
              || ({1'b0, div_res.quotient} >= 13'(NUM_PARTITIONS));
    assign part_base = r_req.key - div_res.remainder;
    assign part_end  = WW'(part_base) + WW'(kpp_eff);
    assign dref_inc  = r_dref_rd + 1'b1;

    always_comb begin
        n_state      = r_state;
        n_clr        = r_clr;
        n_req        = r_req;
        n_head       = r_head;
        n_tail       = r_tail;
        n_fifo_count = r_fifo_count;
        n_status     = r_status;
        n_slab       = r_slab;
        n_rel_cnt    = r_rel_cnt;
        n_walk       = r_walk;
        n_end        = r_end;
        div_start    = 1'b0;
        push_en      = 1'b0;
        push_slab    = r_kv_rd[SW-1:0];
        kv_we        = 1'b0;
        kv_waddr     = KW'(r_req.key);
        kv_wdata     = '0;
        kv_raddr     = KW'(r_req.key);
        fifo_we      = 1'b0;
        fifo_waddr   = r_tail;
        fifo_wdata   = push_slab;
        dref_we      = 1'b0;
        dref_waddr   = r_slab;
        dref_wdata   = '0;
        dref_raddr   = r_kv_rd[SW-1:0];

        unique case (r_state)
            psa_pkg::ST_CLEAR: begin
                kv_waddr   = KW'(r_clr);
                kv_we      = ({1'b0, r_clr} < (CLW+1)'(NUM_KEYS));
                fifo_waddr = SW'(r_clr);
                fifo_wdata = SW'(r_clr);
                fifo_we    = ({1'b0, r_clr} < (CLW+1)'(NUM_SLABS));
                dref_waddr = SW'(r_clr);
                dref_we    = fifo_we;
                n_clr      = r_clr + 1'b1;
                if (r_clr == CLW'(MAXN - 1)) begin
                    n_state = psa_pkg::ST_IDLE;
                end
            end
            psa_pkg::ST_IDLE: begin
                if (start) begin
                    n_req     = i_req;
                    n_status  = psa_pkg::STS_OK;
                    n_slab    = '0;
                    n_rel_cnt = '0;
                    div_start = 1'b1;
                    n_state   = psa_pkg::ST_DIV;
                end
            end
            psa_pkg::ST_DIV: begin
                if (div_res.done) begin
                    if (oor) begin
                        n_status = psa_pkg::STS_OUT_OF_RANGE;
                        n_state  = psa_pkg::ST_DONE;
                    end else begin
                        unique case (r_req.req_type)
                            psa_pkg::REQ_INSERT: begin
                                if (r_fifo_count == '0) begin
                                    n_status = psa_pkg::STS_NO_SLAB;
                                    n_state  = psa_pkg::ST_DONE;
                                end else begin
                                    n_state = psa_pkg::ST_FIFO_USE;
                                end
                            end
                            psa_pkg::REQ_FREE_PART: begin
                                n_walk = WW'(part_base);
                                if ({3'b0, part_end} > 17'(NUM_KEYS)) begin
                                    n_end = WW'(NUM_KEYS);
                                end else begin
                                    n_end = part_end;
                                end
                                n_state = psa_pkg::ST_WALK_RD;
                            end
                            default: begin
                                n_state = psa_pkg::ST_KV_USE;
                            end
                        endcase
                    end
                end
            end
            psa_pkg::ST_FIFO_USE: begin
                // pop the head slab and map the key to it
                n_slab       = r_fifo_rd;
                kv_we        = 1'b1;
                kv_wdata     = {1'b1, r_fifo_rd};
                n_head       = (r_head == SW'(NUM_SLABS - 1)) ? '0 : r_head + 1'b1;
                n_fifo_count = r_fifo_count - 1'b1;
                n_state      = psa_pkg::ST_DONE;
            end
            psa_pkg::ST_KV_USE: begin
                if (!r_kv_rd[SW]) begin
                    n_status = psa_pkg::STS_NOT_MAPPED;
                    n_state  = psa_pkg::ST_DONE;
                end else begin
                    n_slab = r_kv_rd[SW-1:0];
                    if (r_req.req_type == psa_pkg::REQ_GET) begin
                        n_state = psa_pkg::ST_DONE;
                    end else begin
                        n_state = psa_pkg::ST_DREF_USE;
                    end
                end
            end
            psa_pkg::ST_DREF_USE: begin
                dref_we = 1'b1;
                if (dref_inc == r_thr) begin
                    dref_wdata = '0;
                    push_en    = 1'b1;
                    push_slab  = r_slab;
                    kv_we      = 1'b1;
                    kv_wdata   = '0;
                end else begin
                    dref_wdata = dref_inc;
                end
                n_state = psa_pkg::ST_DONE;
            end
            psa_pkg::ST_WALK_RD: begin
                kv_raddr = KW'(r_walk);
                n_state  = psa_pkg::ST_WALK_USE;
            end
            psa_pkg::ST_WALK_USE: begin
                kv_waddr = KW'(r_walk);
                if (r_kv_rd[SW]) begin
                    push_en = 1'b1;
                    kv_we   = 1'b1;
                    kv_wdata = '0;
                end
                n_walk = r_walk + 1'b1;
                if (r_walk + 1'b1 == r_end) begin
                    n_state = psa_pkg::ST_DONE;
                end else begin
                    n_state = psa_pkg::ST_WALK_RD;
                end
            end
            psa_pkg::ST_DONE: begin
                n_state = psa_pkg::ST_IDLE;
            end
            default: begin
                n_state = psa_pkg::ST_IDLE;
            end
        endcase

        // return a slab to the tail; drop it when the list is already full
        if (push_en && (r_fifo_count < CNTW'(NUM_SLABS))) begin
            fifo_we      = 1'b1;
            fifo_waddr   = r_tail;
            fifo_wdata   = push_slab;
            n_tail       = (r_tail == SW'(NUM_SLABS - 1)) ? '0 : r_tail + 1'b1;
            n_fifo_count = r_fifo_count + 1'b1;
            n_rel_cnt    = r_rel_cnt + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= psa_pkg::ST_CLEAR;
            r_clr        <= '0;
            r_head       <= '0;
            r_tail       <= '0;
            r_fifo_count <= CNTW'(NUM_SLABS);
        end else begin
            r_state      <= n_state;
            r_clr        <= n_clr;
            r_head       <= n_head;
            r_tail       <= n_tail;
            r_fifo_count <= n_fifo_count;
        end
    end

    always_ff @(posedge i_clk) begin
        r_req     <= n_req;
        r_status  <= n_status;
        r_slab    <= n_slab;
        r_rel_cnt <= n_rel_cnt;
        r_walk    <= n_walk;
        r_end     <= n_end;
    end

    assign busy                    = (r_state != psa_pkg::ST_IDLE);
    assign o_done                  = (r_state == psa_pkg::ST_DONE);
    assign o_result.status         = r_status;
    assign o_result.slab_index     = (r_status == psa_pkg::STS_OK) ?
                                     psa_pkg::SLAB_OUT_W'(r_slab) : '0;
    assign o_result.released       = (r_rel_cnt != '0);
    assign o_result.released_count = r_rel_cnt;

    // checks
    a_fifo_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fifo_count <= CNTW'(NUM_SLABS))
        else $error("free list count above slab count");

    a_done_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(busy))
        else $error("result strobe without a request in progress");

    a_accept_goes_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> (busy && !o_done))
        else $error("accepted request did not hold busy");

    a_release_only_on_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_result.released) |->
        (r_req.req_type == psa_pkg::REQ_FREE_PART || r_req.req_type == psa_pkg::REQ_FREE_SLAB))
        else $error("slab released by insert or get");

endmodule

FILE: hdl/psa_div.sv
// ----------------------------------------------------------------------------
// psa_div
// Restoring divider: one quotient bit per cycle until all key bits are done.
// ----------------------------------------------------------------------------
module psa_div (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [psa_pkg::KEY_W-1:0]     i_dividend,
    input  logic [psa_pkg::KPP_W-1:0]     i_divisor,
    output psa_pkg::t_div_res             o_res
);

    localparam int STEP_W = $clog2(psa_pkg::KEY_W);

    logic                          r_busy;
    logic                          r_done;
    logic [STEP_W-1:0]             r_step;
    logic [psa_pkg::KEY_W-1:0]     r_quo;
    logic [psa_pkg::KEY_W-1:0]     r_rem;
    logic [psa_pkg::KPP_W-1:0]     r_dvs;

    logic [psa_pkg::KEY_W:0]       trial;
    logic                          ge;

    assign trial = {r_rem, r_quo[psa_pkg::KEY_W-1]};
    assign ge    = (trial >= r_dvs);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
            r_step <= '0;
        end else if (r_busy) begin
            r_step <= r_step + 1'b1;
            if (r_step == STEP_W'(psa_pkg::KEY_W - 1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end else begin
            r_done <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_dvs <= i_divisor;
        end else if (r_busy) begin
            r_quo <= {r_quo[psa_pkg::KEY_W-2:0], ge};
            r_rem <= ge ? psa_pkg::KEY_W'(trial - r_dvs) : trial[psa_pkg::KEY_W-1:0];
        end
    end

    assign o_res.done      = r_done;
    assign o_res.quotient  = r_quo;
    assign o_res.remainder = r_rem;

endmodule

FILE: tb/tb_partitioned_slab_allocator_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_partitioned_slab_allocator_core
// Self-checking bench for the slab allocator: drives random and directed
// requests, predicts every result from a local model of the key map, free
// list and dereference counts, and compares each strobed result field by field.
// ----------------------------------------------------------------------------
module tb_partitioned_slab_allocator_core;

    localparam int NSLAB = 1024;
    localparam int NKEY  = 4096;
    localparam int NPART = 16;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              start = 1'b0;
    logic              busy;
    psa_pkg::t_req     i_req = '0;
    logic              o_done;
    psa_pkg::t_result  o_result;
    logic              psel = 1'b0;
    logic              penable = 1'b0;
    logic              pwrite = 1'b0;
    logic [2:0]        paddr = '0;
    logic [31:0]       pwdata = '0;
    logic [31:0]       prdata;
    logic              pready;

    partitioned_slab_allocator_core dut (.*);

    always #5 i_clk = ~i_clk;

    // allocator model
    logic [12:0] kpp;
    logic [7:0]  thresh;
    bit          mapped [NKEY];
    logic [9:0]  slab_of [NKEY];
    logic [9:0]  free_list [NSLAB];
    int          head, tail, nfree;
    logic [7:0]  derefs [NSLAB];

    psa_pkg::t_req    pending_reqs [$];
    psa_pkg::t_result expected_results [$];
    int      errors = 0;
    bit      stim_done = 0;
    bit      hold_sender = 0;
    int      gap = 0;

    task automatic report(input string msg);
        $display("MISMATCH @%0t: %s", $time, msg);
        errors++;
    endtask

    function automatic bit push_free(input logic [9:0] s);
        if (nfree >= NSLAB) return 0;
        free_list[tail] = s;
        tail = (tail + 1) % NSLAB;
        nfree++;
        return 1;
    endfunction

    function automatic psa_pkg::t_result predict_alloc(input psa_pkg::t_req r);
        psa_pkg::t_result res;
        int k, lim, part, eff;
        logic [7:0] c;
        logic [9:0] s;
        res = '0;
        res.status = psa_pkg::STS_OK;
        eff = (kpp == 0) ? 1 : int'(kpp);
        part = int'(r.key) / eff;
        if (part >= NPART) begin
            res.status = psa_pkg::STS_OUT_OF_RANGE;
        end else begin
            case (r.req_type)
                psa_pkg::REQ_INSERT: begin
                    if (nfree == 0) begin
                        res.status = psa_pkg::STS_NO_SLAB;
                    end else begin
                        res.slab_index = free_list[head];
                        head = (head + 1) % NSLAB;
                        nfree--;
                        slab_of[r.key] = res.slab_index;
                        mapped[r.key] = 1;
                    end
                end
                psa_pkg::REQ_GET: begin
                    if (mapped[r.key]) res.slab_index = slab_of[r.key];
                    else res.status = psa_pkg::STS_NOT_MAPPED;
                end
                psa_pkg::REQ_FREE_PART: begin
                    lim = part * eff + eff;
                    if (lim > NKEY) lim = NKEY;
                    for (k = part * eff; k < lim; k++) begin
                        if (mapped[k]) begin
                            if (push_free(slab_of[k])) res.released_count++;
                            mapped[k] = 0;
                        end
                    end
                    res.released = (res.released_count != 0);
                end
                default: begin
                    if (!mapped[r.key]) begin
                        res.status = psa_pkg::STS_NOT_MAPPED;
                    end else begin
                        s = slab_of[r.key];
                        c = derefs[s] + 8'd1;
                        res.slab_index = s;
                        derefs[s] = c;
                        if (c == thresh) begin
                            if (push_free(s)) begin
                                res.released = 1'b1;
                                res.released_count = 1;
                            end
                            derefs[s] = 0;
                            mapped[r.key] = 0;
                        end
                    end
                end
            endcase
        end
        if (res.status != psa_pkg::STS_OK) res.slab_index = '0;
        return res;
    endfunction

    // driver
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (start && !busy) begin
                expected_results.push_back(predict_alloc(i_req));
                void'(pending_reqs.pop_front());
                start <= 1'b0;
                gap <= $urandom_range(0, 4);
            end else if (!start) begin
                if (gap > 0) begin
                    gap <= gap - 1;
                end else if (pending_reqs.size() != 0 && !hold_sender) begin
                    i_req <= pending_reqs[0];
                    start <= 1'b1;
                end
            end
        end
    end

    // monitor
    always @(posedge i_clk) begin
        if (i_rst_n && o_done) begin
            if (expected_results.size() == 0) begin
                report("result with no request outstanding");
            end else begin
                psa_pkg::t_result e;
                e = expected_results.pop_front();
                if (o_result.status !== e.status)
                    report($sformatf("status %0d exp %0d", o_result.status, e.status));
                if (o_result.slab_index !== e.slab_index)
                    report($sformatf("slab %0d exp %0d", o_result.slab_index,
                                     e.slab_index));
                if (o_result.released !== e.released)
                    report($sformatf("released %0b exp %0b", o_result.released,
                                     e.released));
                if (o_result.released_count !== e.released_count)
                    report($sformatf("count %0d exp %0d", o_result.released_count,
                                     e.released_count));
            end
        end
    end

    task automatic reg_write(input logic reg_sel, input logic [31:0] v);
        @(posedge i_clk);
        psel <= 1'b1; pwrite <= 1'b1; paddr <= {reg_sel, 2'b00}; pwdata <= v;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        if (reg_sel == psa_pkg::REG_KPP) kpp = v[12:0];
        else thresh = v[7:0];
    endtask

    // hold until all requests are done, then let the block settle
    task automatic drain();
        while (pending_reqs.size() != 0 || start || expected_results.size() != 0)
            @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    task automatic add(input psa_pkg::t_req_type t, input int k);
        psa_pkg::t_req r;
        r.req_type = t;
        r.key = k[11:0];
        pending_reqs.push_back(r);
    endtask

    // mostly in-range keys with a random mix of request types
    task automatic random_phase(input int n, input int keyspan);
        int w;
        for (int i = 0; i < n; i++) begin
            w = $urandom_range(0, 99);
            if (w < 5)
                add(psa_pkg::t_req_type'($urandom_range(0, 3)), $urandom_range(0, 4095));
            else if (w < 40) add(psa_pkg::REQ_INSERT, $urandom_range(0, keyspan - 1));
            else if (w < 55) add(psa_pkg::REQ_GET, $urandom_range(0, keyspan - 1));
            else if (w < 60) add(psa_pkg::REQ_FREE_PART, $urandom_range(0, keyspan - 1));
            else add(psa_pkg::REQ_FREE_SLAB, $urandom_range(0, keyspan - 1));
        end
    endtask

    initial begin
        kpp = psa_pkg::KPP_RESET;
        thresh = psa_pkg::THR_RESET;
        head = 0; tail = 0; nfree = NSLAB;
        for (int i = 0; i < NKEY; i++) mapped[i] = 0;
        for (int i = 0; i < NSLAB; i++) begin
            free_list[i] = i[9:0];
            derefs[i] = 0;
        end
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: extremes, every request type, unmapped and overwrite cases
        add(psa_pkg::REQ_GET, 0);
        add(psa_pkg::REQ_FREE_SLAB, 4095);
        add(psa_pkg::REQ_INSERT, 0);
        add(psa_pkg::REQ_INSERT, 4095);
        add(psa_pkg::REQ_GET, 4095);
        add(psa_pkg::REQ_INSERT, 0);
        add(psa_pkg::REQ_GET, 0);
        for (int i = 0; i < 4; i++) add(psa_pkg::REQ_FREE_SLAB, 0);
        add(psa_pkg::REQ_GET, 0);
        add(psa_pkg::REQ_INSERT, 3000);
        add(psa_pkg::REQ_INSERT, 3001);
        add(psa_pkg::REQ_FREE_PART, 3100);
        add(psa_pkg::REQ_FREE_PART, 3100);
        add(psa_pkg::REQ_GET, 3000);
        drain();

        // small partitions so upper keys are out of range, threshold 1
        reg_write(psa_pkg::REG_KPP, 32'd4);
        reg_write(psa_pkg::REG_THR, 32'd1);
        add(psa_pkg::REQ_INSERT, 63);
        add(psa_pkg::REQ_INSERT, 64);
        add(psa_pkg::REQ_FREE_SLAB, 63);
        add(psa_pkg::REQ_FREE_SLAB, 2048);
        random_phase(150, 64);
        drain();

        // zero partition size acts as one; threshold 0 wraps
        reg_write(psa_pkg::REG_KPP, 32'd0);
        reg_write(psa_pkg::REG_THR, 32'd0);
        random_phase(80, 20);
        drain();

        // partition size of the whole key range, max threshold; free the whole key range
        reg_write(psa_pkg::REG_KPP, 32'd4096);
        reg_write(psa_pkg::REG_THR, 32'd255);
        random_phase(60, 4096);
        drain();
        add(psa_pkg::REQ_FREE_PART, 7);
        drain();

        reg_write(psa_pkg::REG_KPP, 32'd256);
        reg_write(psa_pkg::REG_THR, 32'd2);
        random_phase(150, 4096);
        // sender holds off until everything in flight is answered
        while (pending_reqs.size() != 0 || start) @(posedge i_clk);
        hold_sender = 1;
        random_phase(80, 4096);
        while (expected_results.size() != 0) @(posedge i_clk);
        hold_sender = 0;
        drain();

        reg_write(psa_pkg::REG_KPP, 32'd8191);
        reg_write(psa_pkg::REG_THR, 32'd3);
        random_phase(40, 4096);
        drain();

        reg_write(psa_pkg::REG_KPP, 32'd16);
        random_phase(200, 256);
        drain();
        stim_done = 1;
    end

    initial begin
        wait (stim_done);
        if (errors == 0) $display("Verification passed");
        else $display("Verification failed");
        $finish;
    end

    initial begin
        #300ms;
        $display("Verification failed");
        $finish;
    end
endmodule
